// ===== design/order_statistic_multiset_unit_assert.svh =====
// Assertion macros for the order statistic multiset unit.
// Included by design/order_statistic_multiset_unit.sv; no other dependencies.
`ifndef ORDER_STATISTIC_MULTISET_UNIT_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OSM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OSM_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OSM_ASSERT(label, clk, rst, prop, msg)
`define OSM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== design/osm_pkg.sv =====
// Types and codes for the order statistic multiset unit.
// No dependencies.
package osm_pkg;
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_SWAIT, S_SHIFT, S_QWAIT, S_DONE
  } state_t;
endpackage

// ===== design/order_statistic_multiset_unit.sv =====
// Order statistic multiset: sorted keys in one RAM with registered read. Uses osm_pkg.
// Insert/delete do a binary search, then shift entries; a query does one RAM read.
// One request at a time: a new request is accepted only after the result is taken.
// A binary search probe takes S_SRCH (address) then S_SWAIT (registered data); a shift
// moves one entry per cycle.
// Reset (rst, synchronous): count is zero, RAM contents are left as they were.
`include "order_statistic_multiset_unit_assert.svh"
module order_statistic_multiset_unit #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: value[31:0], rank[42:32], zero pad [47:43]
  input  logic [47:0] s_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: result_key[31:0], status[33:32], count[44:34], zero pad [47:45]
  output logic [47:0] m_tdata
);
  localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0] mem [CAPACITY];
  logic [31:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic [31:0] wdata;
  logic        we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  osm_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] lo, lo_next, hi, hi_next, pos, pos_next;
  logic [1:0]    kind, kind_next;
  logic [31:0]   key, key_next;
  logic [31:0]   rkey, rkey_next;
  logic [1:0]    st, st_next;
  logic [CW-1:0] mid;
  logic          less;

  assign mid = lo + ((hi - lo) >> 1);
  // insert: upper bound (key < mem -> hi); delete: lower bound (mem < key -> lo)
  assign less = (kind == osm_pkg::KIND_INSERT) ? ($signed(key) < $signed(rdata))
                                               : !($signed(rdata) < $signed(key));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= osm_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    lo <= lo_next; hi <= hi_next; pos <= pos_next;
    kind <= kind_next; key <= key_next; rkey <= rkey_next; st <= st_next;
  end

  always_comb begin
    state_next = state; count_next = count;
    lo_next = lo; hi_next = hi; pos_next = pos;
    kind_next = kind; key_next = key; rkey_next = rkey; st_next = st;
    raddr = mid[AW-1:0]; waddr = pos[AW-1:0]; wdata = key; we = 1'b0;
    s_tready = 1'b0; m_tvalid = 1'b0;
    case (state)
      osm_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          kind_next = s_tuser; key_next = s_tdata[31:0];
          rkey_next = '0; st_next = osm_pkg::ST_OK;
          lo_next = '0; hi_next = count;
          raddr = AW'(s_tdata[42:32] - 11'd1);
          case (s_tuser)
            osm_pkg::KIND_INSERT: begin
              if (count >= CW'(CAPACITY)) begin
                st_next = osm_pkg::ST_FULL; state_next = osm_pkg::S_DONE;
              end else state_next = osm_pkg::S_SRCH;
            end
            osm_pkg::KIND_DELETE: state_next = osm_pkg::S_SRCH;
            osm_pkg::KIND_QUERY: begin
              if (s_tdata[42:32] == 11'd0 ||
                  {{(CW > 11 ? CW-11 : 0){1'b0}}, s_tdata[42:32]} > CW'(count)) begin
                st_next = osm_pkg::ST_NOTFOUND; state_next = osm_pkg::S_DONE;
              end else state_next = osm_pkg::S_QWAIT;
            end
            default: begin
              count_next = '0; state_next = osm_pkg::S_DONE;
            end
          endcase
        end
      end
      osm_pkg::S_QWAIT: begin
        rkey_next = rdata; state_next = osm_pkg::S_DONE;
      end
      osm_pkg::S_SRCH: begin
        if (lo < hi) state_next = osm_pkg::S_SWAIT;
        else if (kind == osm_pkg::KIND_INSERT) begin
          pos_next = count; raddr = AW'(count - CW'(1));
          state_next = osm_pkg::S_SHIFT;
        end else begin
          pos_next = lo; raddr = lo[AW-1:0];
          state_next = osm_pkg::S_SHIFT;
        end
      end
      osm_pkg::S_SWAIT: begin
        if (less) hi_next = mid; else lo_next = mid + CW'(1);
        state_next = osm_pkg::S_SRCH;
      end
      osm_pkg::S_SHIFT: begin
        // rdata holds the entry addressed last cycle
        if (kind == osm_pkg::KIND_INSERT) begin
          if (pos == lo) begin
            we = 1'b1; wdata = key; count_next = count + CW'(1);
            state_next = osm_pkg::S_DONE;
          end else begin
            we = 1'b1; wdata = rdata; pos_next = pos - CW'(1);
            raddr = AW'(pos - CW'(2));
          end
        end else begin
          if (pos == lo && (lo >= count || rdata != key)) begin
            st_next = osm_pkg::ST_NOTFOUND; state_next = osm_pkg::S_DONE;
          end else begin
            if (pos != lo) begin
              we = 1'b1; waddr = AW'(pos - CW'(1)); wdata = rdata;
            end
            if (pos + CW'(1) >= count) begin
              rkey_next = key; count_next = count - CW'(1);
              state_next = osm_pkg::S_DONE;
            end else begin
              pos_next = pos + CW'(1); raddr = AW'(pos + CW'(1));
            end
          end
        end
      end
      osm_pkg::S_DONE: begin
        m_tvalid = 1'b1;
        if (m_tready) state_next = osm_pkg::S_IDLE;
      end
      default: state_next = osm_pkg::S_IDLE;
    endcase
  end

  logic [10:0] count_out;
  assign count_out = 11'(count);
  assign m_tdata = {3'b000, count_out, st, rkey};

  `OSM_ASSERT(a_count_cap, clk, rst, (count <= CW'(CAPACITY)), "count exceeds capacity")
  `OSM_ASSERT(a_no_accept_busy, clk, rst, (s_tready |-> !m_tvalid), "ready while result held")
  `OSM_ASSERT(a_hold_result, clk, rst, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)), "result dropped")
  `OSM_ASSERT_NR(a_reset_count, clk, (rst |=> count == '0), "count not cleared")
endmodule

// ===== bench/tb_order_statistic_multiset_unit.sv =====
// Testbench for order_statistic_multiset_unit: directed table, a fill to capacity, then random
// requests, all checked against a sorted-queue predictor. Depends on osm_pkg and the unit.
module tb_order_statistic_multiset_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 1024;
  localparam int NUM_RANDOM = 850;
  localparam longint CYCLE_LIMIT = 20000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = osm_pkg::KIND_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  // one expected response
  typedef struct packed {
    logic signed [31:0] key;
    logic [1:0]         status;
    logic [10:0]        count;
  } resp_t;

  // one directed row; chk set means the typed-in response is also compared
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [10:0] rank;
    bit          chk;
    resp_t       resp;
  } row_t;

  logic signed [31:0] held_keys[$];   // predictor copy of the set, ascending
  resp_t              pending_resp[$];
  row_t               rows[$];
  int                 errors = 0;
  int                 responses = 0;
  int                 stall = 0;
  longint             cycles = 0;

  order_statistic_multiset_unit #(.CAPACITY(CAP)) i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata
  );

  always #6 clk = ~clk;

  // predictor: updates the held set and returns the response
  function automatic resp_t model_op(logic [1:0] kind, logic signed [31:0] v,
                                     logic [10:0] rk);
    resp_t r;
    int p;
    r = '0;
    case (kind)
      osm_pkg::KIND_INSERT: begin
        if (held_keys.size() >= CAP) r.status = osm_pkg::ST_FULL;
        else begin
          p = 0;
          while (p < held_keys.size() && held_keys[p] <= v) p++;
          held_keys.insert(p, v);
        end
      end
      osm_pkg::KIND_DELETE: begin
        p = 0;
        while (p < held_keys.size() && held_keys[p] < v) p++;
        if (p < held_keys.size() && held_keys[p] == v) begin
          r.key = v;
          held_keys.delete(p);
        end else r.status = osm_pkg::ST_NOTFOUND;
      end
      osm_pkg::KIND_QUERY: begin
        if (rk == 0 || rk > held_keys.size()) r.status = osm_pkg::ST_NOTFOUND;
        else r.key = held_keys[rk-1];
      end
      default: held_keys.delete();
    endcase
    r.count = 11'(held_keys.size());
    return r;
  endfunction

  function automatic row_t mk(logic [1:0] k, logic [31:0] v, logic [10:0] rk,
                              bit c = 0, logic [31:0] ek = 0,
                              logic [1:0] es = osm_pkg::ST_OK, logic [10:0] ec = 0);
    row_t r;
    r.kind = k; r.value = v; r.rank = rk; r.chk = c;
    r.resp.key = ek; r.resp.status = es; r.resp.count = ec;
    return r;
  endfunction

  // random idle length: mostly short, sometimes long, sometimes none
  function automatic int gap_len();
    int d;
    d = $urandom_range(0, 99);
    if (d < 45) return 0;
    if (d < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one request, predict at acceptance; starts and ends at a falling edge
  task automatic send(logic [1:0] k, logic [31:0] v, logic [10:0] rk, bit chk,
                      resp_t typed);
    resp_t r;
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {5'b0, rk, v};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = model_op(k, v, rk);
    if (chk && r !== typed) begin
      $error("table row: exp key %0d status %0d count %0d, predictor key %0d status %0d count %0d",
             typed.key, typed.status, typed.count, r.key, r.status, r.count);
      errors++;
    end
    pending_resp.push_back(r);
    @(negedge clk);
  endtask

  // response side: stall runs of random length
  always @(negedge clk) begin
    if (!rst) begin
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        stall = gap_len();
        m_tready <= (stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    resp_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      responses++;
      if (pending_resp.size() == 0) begin
        $error("response with none expected: %h", m_tdata);
        errors++;
      end else begin
        e = pending_resp.pop_front();
        if (m_tdata[31:0] !== e.key) begin
          $error("result_key exp %0d got %0d", e.key, $signed(m_tdata[31:0])); errors++;
        end
        if (m_tdata[33:32] !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_tdata[33:32]); errors++;
        end
        if (m_tdata[44:34] !== e.count) begin
          $error("count exp %0d got %0d", e.count, m_tdata[44:34]); errors++;
        end
      end
    end
  end

  // key pool mixes extremes, a small range and held keys for duplicates, and full-width noise
  function automatic logic [31:0] pick_key();
    int d;
    d = $urandom_range(0, 9);
    if (d < 5) return $urandom_range(0, 40) - 20;
    if (d < 6) return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    if (d < 8 && held_keys.size() > 0) return held_keys[$urandom_range(0, held_keys.size()-1)];
    return $urandom;
  endfunction

  initial begin
    int k, n;
    logic [1:0] kind;
    logic [31:0] v;
    logic [10:0] rk;
    resp_t none;
    none = '0;
    // directed table: empty-set errors, extremes, duplicates, clear
    rows.push_back(mk(osm_pkg::KIND_QUERY,  0, 1, 1, 0, osm_pkg::ST_NOTFOUND, 0));
    rows.push_back(mk(osm_pkg::KIND_DELETE, 5, 0, 1, 0, osm_pkg::ST_NOTFOUND, 0));
    rows.push_back(mk(osm_pkg::KIND_INSERT, 32'h8000_0000, 0, 1, 0, osm_pkg::ST_OK, 1));
    rows.push_back(mk(osm_pkg::KIND_INSERT, 32'h7fff_ffff, 0, 1, 0, osm_pkg::ST_OK, 2));
    rows.push_back(mk(osm_pkg::KIND_INSERT, 32'hffff_ffff, 0, 1, 0, osm_pkg::ST_OK, 3));
    rows.push_back(mk(osm_pkg::KIND_INSERT, 0, 0, 1, 0, osm_pkg::ST_OK, 4));
    rows.push_back(mk(osm_pkg::KIND_INSERT, 0, 0, 1, 0, osm_pkg::ST_OK, 5));
    rows.push_back(mk(osm_pkg::KIND_QUERY,  0, 1, 1, 32'h8000_0000, osm_pkg::ST_OK, 5));
    rows.push_back(mk(osm_pkg::KIND_QUERY,  0, 5, 1, 32'h7fff_ffff, osm_pkg::ST_OK, 5));
    rows.push_back(mk(osm_pkg::KIND_QUERY,  0, 0, 1, 0, osm_pkg::ST_NOTFOUND, 5));
    rows.push_back(mk(osm_pkg::KIND_QUERY,  0, 6, 1, 0, osm_pkg::ST_NOTFOUND, 5));
    rows.push_back(mk(osm_pkg::KIND_QUERY,  0, 11'h7ff, 1, 0, osm_pkg::ST_NOTFOUND, 5));
    rows.push_back(mk(osm_pkg::KIND_QUERY,  0, 2));
    rows.push_back(mk(osm_pkg::KIND_DELETE, 0, 0, 1, 0, osm_pkg::ST_OK, 4));
    rows.push_back(mk(osm_pkg::KIND_DELETE, 1, 0, 1, 0, osm_pkg::ST_NOTFOUND, 4));
    rows.push_back(mk(osm_pkg::KIND_QUERY,  0, 3));
    rows.push_back(mk(osm_pkg::KIND_DELETE, 32'h8000_0000, 0, 1, 32'h8000_0000,
                      osm_pkg::ST_OK, 3));
    rows.push_back(mk(osm_pkg::KIND_DELETE, 32'h7fff_ffff, 0, 1, 32'h7fff_ffff,
                      osm_pkg::ST_OK, 2));
    rows.push_back(mk(osm_pkg::KIND_CLEAR,  32'hffff_ffff, 11'h7ff, 1, 0, osm_pkg::ST_OK, 0));
    rows.push_back(mk(osm_pkg::KIND_QUERY,  0, 1, 1, 0, osm_pkg::ST_NOTFOUND, 0));
    rows.push_back(mk(osm_pkg::KIND_DELETE, 32'hffff_ffff, 0, 1, 0, osm_pkg::ST_NOTFOUND, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send(rows[i].kind, rows[i].value, rows[i].rank, rows[i].chk,
                           rows[i].resp);

    // fill to capacity once, then probe the full case
    for (k = 0; k < CAP; k++)
      send(osm_pkg::KIND_INSERT, $urandom_range(0, 3000) - 1500, 0, 0, none);
    send(osm_pkg::KIND_INSERT, 32'h7fff_ffff, 0, 1, '{0, osm_pkg::ST_FULL, 11'(CAP)});
    send(osm_pkg::KIND_QUERY, 0, 11'(CAP), 0, none);
    send(osm_pkg::KIND_QUERY, 0, 11'(CAP + 1), 1, '{0, osm_pkg::ST_NOTFOUND, 11'(CAP)});
    send(osm_pkg::KIND_CLEAR, 0, 0, 0, none);

    // random part: insert-heavy mix with deletes and queries, rare clears
    for (n = 0; n < NUM_RANDOM; n++) begin
      k = $urandom_range(0, 99);
      if (k < 45) kind = osm_pkg::KIND_INSERT;
      else if (k < 70) kind = osm_pkg::KIND_DELETE;
      else if (k < 99) kind = osm_pkg::KIND_QUERY;
      else kind = osm_pkg::KIND_CLEAR;
      v = pick_key();
      if ($urandom_range(0, 4) == 0) rk = 11'($urandom);
      else rk = 11'($urandom_range(0, held_keys.size() + 1));
      send(kind, v, rk, 0, none);
    end
    s_tvalid <= 1'b0;

    while (pending_resp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d responses incl. a full fill to %0d keys, extremes, duplicates",
             responses, CAP);
    if (errors == 0 && pending_resp.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/osm_pkg.sv
design/order_statistic_multiset_unit.sv
bench/tb_order_statistic_multiset_unit.sv
